[hw/rtl/sto_pkg.sv]
package sto_pkg;

    localparam int TIMER_COUNT_DEFAULT = 8;
    localparam int MAX_RESULTS         = 8;
    localparam int COUNT_W             = 4;
    localparam int ID_W                = 3;
    localparam int ID_COUNT            = 1 << ID_W;
    localparam int MAX_PRESCALE        = 4;

    localparam logic [2:0] REQ_TICK      = 3'd0;
    localparam logic [2:0] REQ_START_ABS = 3'd1;
    localparam logic [2:0] REQ_START_REL = 3'd2;
    localparam logic [2:0] REQ_STOP      = 3'd3;
    localparam logic [2:0] REQ_READ      = 3'd4;

    localparam logic RES_EXPIRED = 1'b0;
    localparam logic RES_TIME    = 1'b1;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [2:0]  timer_id;
        logic [31:0] expiry_time;
        logic [31:0] delay_usecs;
    } t_request;

    typedef struct packed {
        logic        result_kind;
        logic [2:0]  expired_timer;
        logic [63:0] time_value;
        logic        last;
    } t_result;

    typedef struct packed {
        logic [31:0]     expiry;
        logic [ID_W-1:0] owner;
    } t_slot;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_REMOVE = 2'd1,
        OP_INSERT = 2'd2,
        OP_POP    = 2'd3
    } t_cell_op;

    typedef struct packed {
        t_cell_op        op;
        logic [ID_W-1:0] id;
        logic [31:0]     when;
        logic [31:0]     time_low;
    } t_cell_ctrl;

endpackage

[hw/rtl/sorted_expiry_timer_queue.sv]
// Steps: tick, unused codes and ignored requests go straight to the expiry sweep; stop
//   removes, then sweeps; start removes a queued timer, inserts, then sweeps; read answers,
//   then sweeps. The sweep pops one head a cycle, one expiry result each. One item at a time:
//   busy stays high until the sweep ends, so the next item cannot start before then.
// Results appear on o_result for one cycle with o_strobe; the receiver cannot stall.
// Reset (synchronous, active low) clears state, time, queue length, queued flags, result count, strobe and prescale.
module sorted_expiry_timer_queue #(
    parameter int TIMER_COUNT = sto_pkg::TIMER_COUNT_DEFAULT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  sto_pkg::t_request i_req,
    output logic              o_strobe,
    output sto_pkg::t_result  o_result,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_wdata
);

    localparam int LEN_W = $clog2(TIMER_COUNT + 1);

    // Sequencer: the queue itself is the row of cells below, this only
    // steps one item through remove, insert, read answer and the expiry sweep.
    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_REMOVE = 5'b00010,
        S_INSERT = 5'b00100,
        S_READ   = 5'b01000,
        S_SWEEP  = 5'b10000
    } t_state;

    t_state                        r_state, n_state;
    logic [31:0]                   r_time_low, n_time_low;
    logic [31:0]                   r_time_high, n_time_high;
    logic [LEN_W-1:0]              r_len, n_len;
    logic [sto_pkg::ID_COUNT-1:0]  r_queued, n_queued;
    logic [sto_pkg::COUNT_W-1:0]   r_count, n_count;
    logic [2:0]                    r_prescale;
    logic                          r_strobe, n_strobe;
    sto_pkg::t_result              r_result, n_result;

    // latched item
    logic [2:0]                    r_req_type;
    logic [sto_pkg::ID_W-1:0]      r_id;
    logic [31:0]                   r_when;
    logic [31:0]                   n_when;

    sto_pkg::t_cell_ctrl           cell_ctrl;
    sto_pkg::t_slot                slot [TIMER_COUNT];
    logic [TIMER_COUNT:0]          found;
    logic [TIMER_COUNT-1:0]        occupied;
    logic [TIMER_COUNT-1:0]        expired;
    logic                          head_exp;
    logic                          next_exp;
    logic                          id_ok;
    logic                          pop;
    logic [2:0]                    shift;
    logic [63:0]                   time_inc;

    // ---------------------------------------------------------------
    // Row of cells: entry 0 is the head of the sorted queue.
    // ---------------------------------------------------------------
    assign found[0] = 1'b0;

    for (genvar k = 0; k < TIMER_COUNT; k++) begin : g_cell
        sto_pkg::t_slot left_slot;
        sto_pkg::t_slot right_slot;

        assign occupied[k] = LEN_W'(k) < r_len;
        if (k == 0) begin : g_first
            assign left_slot = '0;
        end else begin : g_inner_l
            assign left_slot = slot[k-1];
        end
        if (k == TIMER_COUNT - 1) begin : g_last
            assign right_slot = slot[k];
        end else begin : g_inner_r
            assign right_slot = slot[k+1];
        end

        sto_cell u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (cell_ctrl),
            .i_occupied (occupied[k]),
            .i_found    (found[k]),
            .o_found    (found[k+1]),
            .i_left     (left_slot),
            .i_right    (right_slot),
            .o_slot     (slot[k]),
            .o_expired  (expired[k])
        );
    end

    assign head_exp = expired[0];
    if (TIMER_COUNT > 1) begin : g_next
        assign next_exp = expired[1];
    end else begin : g_no_next
        assign next_exp = 1'b0;
    end

    // ---------------------------------------------------------------
    // Item decode and relative expiry: ticks per microsecond is
    // 16 >> code, so the product is a left shift by 4 - code (no shift for codes above 4).
    // ---------------------------------------------------------------
    assign id_ok    = 32'(i_req.timer_id) < 32'(TIMER_COUNT);
    assign time_inc = {r_time_high, r_time_low} + 64'd1;
    assign pop      = head_exp && (r_count < sto_pkg::COUNT_W'(sto_pkg::MAX_RESULTS));

    always_comb begin
        if (r_prescale > 3'(sto_pkg::MAX_PRESCALE)) begin
            shift = 3'd0;
        end else begin
            shift = 3'(sto_pkg::MAX_PRESCALE) - r_prescale;
        end
        if (i_req.req_type == sto_pkg::REQ_START_ABS) begin
            n_when = i_req.expiry_time;
        end else begin
            n_when = r_time_low + (i_req.delay_usecs << shift);
        end
    end

    always_comb begin
        n_state     = r_state;
        n_time_low  = r_time_low;
        n_time_high = r_time_high;
        n_len       = r_len;
        n_queued    = r_queued;
        n_count     = r_count;
        n_strobe    = 1'b0;
        n_result    = r_result;

        cell_ctrl.op       = sto_pkg::OP_HOLD;
        cell_ctrl.id       = r_id;
        cell_ctrl.when     = r_when;
        cell_ctrl.time_low = r_time_low;

        unique case (r_state)
            S_IDLE: begin
                n_count = '0;
                if (start) begin
                    n_state = S_SWEEP;
                    case (i_req.req_type) inside
                        sto_pkg::REQ_TICK: begin
                            n_time_low  = time_inc[31:0];
                            n_time_high = time_inc[63:32];
                        end
                        sto_pkg::REQ_START_ABS, sto_pkg::REQ_START_REL: begin
                            // restart of a queued timer removes it first
                            if (id_ok) begin
                                n_state = r_queued[i_req.timer_id] ? S_REMOVE : S_INSERT;
                            end
                        end
                        sto_pkg::REQ_STOP: begin
                            // stop of an idle timer is ignored
                            if (id_ok && r_queued[i_req.timer_id]) begin
                                n_state = S_REMOVE;
                            end
                        end
                        sto_pkg::REQ_READ: begin
                            n_state = S_READ;
                        end
                        default: begin
                            n_state = S_SWEEP;
                        end
                    endcase
                end
            end
            S_REMOVE: begin
                cell_ctrl.op   = sto_pkg::OP_REMOVE;
                n_len          = r_len - LEN_W'(1);
                n_queued[r_id] = 1'b0;
                n_state        = (r_req_type == sto_pkg::REQ_STOP) ? S_SWEEP : S_INSERT;
            end
            S_INSERT: begin
                // a full queue drops the new timer
                if (r_len < LEN_W'(TIMER_COUNT)) begin
                    cell_ctrl.op   = sto_pkg::OP_INSERT;
                    n_len          = r_len + LEN_W'(1);
                    n_queued[r_id] = 1'b1;
                end
                n_state = S_SWEEP;
            end
            S_READ: begin
                n_strobe               = 1'b1;
                n_result.result_kind   = sto_pkg::RES_TIME;
                n_result.expired_timer = '0;
                n_result.time_value    = {r_time_high, r_time_low};
                n_result.last          = !head_exp;
                n_count                = sto_pkg::COUNT_W'(1);
                n_state                = S_SWEEP;
            end
            S_SWEEP: begin
                // one head pop a cycle; last is known from the second entry
                if (pop) begin
                    cell_ctrl.op           = sto_pkg::OP_POP;
                    n_len                  = r_len - LEN_W'(1);
                    n_queued[slot[0].owner] = 1'b0;
                    n_count                = r_count + sto_pkg::COUNT_W'(1);
                    n_strobe               = 1'b1;
                    n_result.result_kind   = sto_pkg::RES_EXPIRED;
                    n_result.expired_timer = slot[0].owner;
                    n_result.time_value    = '0;
                    n_result.last          = !(next_exp && (r_count + sto_pkg::COUNT_W'(1)
                                               < sto_pkg::COUNT_W'(sto_pkg::MAX_RESULTS)));
                    if (n_result.last) begin
                        n_state = S_IDLE;
                    end
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_time_low  <= '0;
            r_time_high <= '0;
            r_len       <= '0;
            r_queued    <= '0;
            r_count     <= '0;
            r_strobe    <= 1'b0;
            r_prescale  <= 3'd0;
        end else begin
            r_state     <= n_state;
            r_time_low  <= n_time_low;
            r_time_high <= n_time_high;
            r_len       <= n_len;
            r_queued    <= n_queued;
            r_count     <= n_count;
            r_strobe    <= n_strobe;
            if (i_cfg_we) begin
                r_prescale <= i_cfg_wdata;
            end
        end
    end

    // payload: no reset
    always_ff @(posedge i_clk) begin
        r_result <= n_result;
        if (r_state == S_IDLE && start) begin
            r_req_type <= i_req.req_type;
            r_id       <= i_req.timer_id;
            r_when     <= n_when;
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_W'(TIMER_COUNT))
        else $error("queue length above slot count");

    a_queued_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_queued) == int'(r_len))
        else $error("queued flags disagree with queue length");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= sto_pkg::COUNT_W'(sto_pkg::MAX_RESULTS))
        else $error("too many results for one item");

    a_more_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_result.last |-> busy)
        else $error("result without last while idle");

    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result strobe from idle state");

endmodule

[hw/rtl/sto_cell.sv]
// One queue slot. Search flag ripples left to right through the row.
module sto_cell (
    input  logic               i_clk,
    input  sto_pkg::t_cell_ctrl i_ctrl,
    input  logic               i_occupied,
    input  logic               i_found,
    output logic               o_found,
    input  sto_pkg::t_slot     i_left,
    input  sto_pkg::t_slot     i_right,
    output sto_pkg::t_slot     o_slot,
    output logic               o_expired
);

    sto_pkg::t_slot r_slot;
    sto_pkg::t_slot n_slot;
    logic [31:0]    diff_new;
    logic [31:0]    diff_now;
    logic           hit;

    always_comb begin
        diff_new = i_ctrl.when - r_slot.expiry;
        diff_now = i_ctrl.time_low - r_slot.expiry;
        // insert: first slot that expires later, or first empty slot
        if (i_ctrl.op == sto_pkg::OP_REMOVE) begin
            hit = i_occupied && (r_slot.owner == i_ctrl.id);
        end else begin
            hit = !i_occupied || diff_new[31];
        end
        o_found = i_found || hit;
        n_slot  = r_slot;
        unique case (i_ctrl.op)
            sto_pkg::OP_HOLD: begin
                n_slot = r_slot;
            end
            sto_pkg::OP_REMOVE: begin
                if (o_found) begin
                    n_slot = i_right;
                end
            end
            sto_pkg::OP_INSERT: begin
                if (i_found) begin
                    n_slot = i_left;
                end else if (hit) begin
                    n_slot.expiry = i_ctrl.when;
                    n_slot.owner  = i_ctrl.id;
                end
            end
            sto_pkg::OP_POP: begin
                n_slot = i_right;
            end
            default: begin
                n_slot = r_slot;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
    end

    assign o_slot    = r_slot;
    assign o_expired = i_occupied && !diff_now[31];

endmodule
